// ===== src/otpd_pkg.sv =====
// Package with shared constants, types and helpers for the ordered two-pattern detector.
`timescale 1ns / 1ps
`default_nettype none

package otpd_pkg;

    // Field and register widths.
    localparam int BYTE_W          = 8;
    localparam int PAT_W           = 64;
    localparam int LEN_W           = 4;
    localparam int GAP_W           = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int VERDICT_W       = 2;
    localparam int DEFAULT_MAX_PAT = 8;

    // Gap counters saturate at this value.
    localparam logic [GAP_W-1:0] GAP_MAX = 4'd15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_PATTERN  = 2'd0,
        REG_FIRST_LENGTH   = 2'd1,
        REG_SECOND_PATTERN = 2'd2,
        REG_SECOND_LENGTH  = 2'd3
    } cfg_reg_t;

    // Bit positions inside the verdict.
    localparam int VERDICT_FWD_BIT = 0;
    localparam int VERDICT_BWD_BIT = 1;

    // Effective pattern length: zero counts as one, large values clip to the maximum.
    function automatic logic [LEN_W-1:0] eff_len(
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] max_len
    );
        logic [LEN_W-1:0] res;
        begin
            if (len == '0)
            begin
                res = LEN_W'(1);
            end
            else if (len > max_len)
            begin
                res = max_len;
            end
            else
            begin
                res = len;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/ordered_two_pattern_detector.sv =====
// Timing: a text byte is registered in the input register on acceptance and processed from there;
// the verdict is loaded into the output register when the last byte of a text is processed.
// Throughput: one text byte per cycle, set by the single-pass window compare stage.
// The input stalls only when a last byte meets a verdict that is still waiting.
// Reset (asynchronous, active low) clears the window, the search state and the output valid flag,
// and returns the patterns to zero and the lengths to one.
`timescale 1ns / 1ps
`default_nettype none

module ordered_two_pattern_detector
    import otpd_pkg::*;
#(
    parameter int MAX_PATTERN = DEFAULT_MAX_PAT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0]     cfg_data,

    input  wire logic                 text_valid,
    output logic                      text_stall,
    input  wire logic [BYTE_W-1:0]    text_byte,
    input  wire logic                 last_byte,

    output logic                      verdict_valid,
    input  wire logic                 verdict_stall,
    output logic [VERDICT_W-1:0]      verdict
);

    localparam int WIN_W  = MAX_PATTERN * BYTE_W;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PATTERN);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

    // Configuration registers.
    logic [PAT_W-1:0] first_pattern_reg;
    logic [LEN_W-1:0] first_length_reg;
    logic [PAT_W-1:0] second_pattern_reg;
    logic [LEN_W-1:0] second_length_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Search state.
    logic [WIN_W-1:0]  window_reg,    window_next;
    logic [FILL_W-1:0] fill_reg,      fill_next;
    logic              fwd_seen_reg,  fwd_seen_next;
    logic [GAP_W-1:0]  fwd_gap_reg,   fwd_gap_next;
    logic              fwd_found_reg, fwd_found_next;
    logic              bwd_seen_reg,  bwd_seen_next;
    logic [GAP_W-1:0]  bwd_gap_reg,   bwd_gap_next;
    logic              bwd_found_reg, bwd_found_next;

    // Output register.
    logic                 verdict_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg;

    logic             process;
    logic             can_process;
    logic [LEN_W-1:0] len1;
    logic [LEN_W-1:0] len2;
    logic [FILL_W-1:0] fill_upd;
    logic [WIN_W-1:0] window_upd;
    logic             fwd_match1;
    logic             fwd_match2;
    logic             rev_match1;
    logic             rev_match2;
    logic [MAX_PATTERN-1:0] rev_eq1;
    logic [MAX_PATTERN-1:0] rev_eq2;
    logic [MAX_PATTERN-1:0] mask1;
    logic [MAX_PATTERN-1:0] mask2;
    logic             fwd_found_upd;
    logic             bwd_found_upd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pattern_reg  <= '0;
            first_length_reg   <= LEN_W'(1);
            second_pattern_reg <= '0;
            second_length_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FIRST_PATTERN:  first_pattern_reg  <= cfg_data;
                REG_FIRST_LENGTH:   first_length_reg   <= cfg_data[LEN_W-1:0];
                REG_SECOND_PATTERN: second_pattern_reg <= cfg_data;
                REG_SECOND_LENGTH:  second_length_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A last byte can be processed only when the output register is free to take its verdict.
    assign can_process = !(in_last_reg && verdict_valid_reg && verdict_stall);
    assign process     = in_valid_reg && can_process;
    assign text_stall  = in_valid_reg && !can_process;

    // Input register loads each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall && text_valid)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= last_byte;
        end
    end

    // Window shift and fill count for the byte being processed.
    assign len1       = eff_len(first_length_reg, MAX_LEN);
    assign len2       = eff_len(second_length_reg, MAX_LEN);
    assign window_upd = WIN_W'({window_reg, in_byte_reg});
    assign fill_upd   = (fill_reg < FILL_MAX) ? fill_reg + FILL_W'(1) : fill_reg;

    // Pattern in text order ending at the newest byte: one candidate per length.
    always_comb
    begin
        logic ok1;
        logic ok2;
        fwd_match1 = 1'b0;
        fwd_match2 = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            ok1 = 1'b1;
            ok2 = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (window_upd[BYTE_W*k +: BYTE_W] !=
                    first_pattern_reg[BYTE_W*(l-1-k) +: BYTE_W])
                begin
                    ok1 = 1'b0;
                end
                if (window_upd[BYTE_W*k +: BYTE_W] !=
                    second_pattern_reg[BYTE_W*(l-1-k) +: BYTE_W])
                begin
                    ok2 = 1'b0;
                end
            end
            if (len1 == LEN_W'(l))
            begin
                fwd_match1 = ok1;
            end
            if (len2 == LEN_W'(l))
            begin
                fwd_match2 = ok2;
            end
        end
        if (LEN_W'(fill_upd) < len1)
        begin
            fwd_match1 = 1'b0;
        end
        if (LEN_W'(fill_upd) < len2)
        begin
            fwd_match2 = 1'b0;
        end
    end

    // Reversed pattern ending at the newest byte: bytewise compare under a length mask.
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            rev_eq1[k] = window_upd[BYTE_W*k +: BYTE_W] == first_pattern_reg[BYTE_W*k +: BYTE_W];
            rev_eq2[k] = window_upd[BYTE_W*k +: BYTE_W] == second_pattern_reg[BYTE_W*k +: BYTE_W];
            mask1[k]   = LEN_W'(k) < len1;
            mask2[k]   = LEN_W'(k) < len2;
        end
        rev_match1 = (&(rev_eq1 | ~mask1)) && (LEN_W'(fill_upd) >= len1);
        rev_match2 = (&(rev_eq2 | ~mask2)) && (LEN_W'(fill_upd) >= len2);
    end

    // Forward and backward search progress.
    always_comb
    begin
        fwd_seen_next  = fwd_seen_reg;
        fwd_gap_next   = fwd_gap_reg;
        fwd_found_upd  = fwd_found_reg;
        bwd_seen_next  = bwd_seen_reg;
        bwd_gap_next   = bwd_gap_reg;
        bwd_found_upd  = bwd_found_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;

        if (process)
        begin
            window_next = window_upd;
            fill_next   = fill_upd;

            if (fwd_seen_reg)
            begin
                if (fwd_gap_reg < GAP_MAX)
                begin
                    fwd_gap_next = fwd_gap_reg + GAP_W'(1);
                end
                if (!fwd_found_reg && fwd_gap_next >= len2 && fwd_match2)
                begin
                    fwd_found_upd = 1'b1;
                end
            end
            else if (fwd_match1)
            begin
                fwd_seen_next = 1'b1;
                fwd_gap_next  = '0;
            end

            if (bwd_seen_reg)
            begin
                if (bwd_gap_reg < GAP_MAX)
                begin
                    bwd_gap_next = bwd_gap_reg + GAP_W'(1);
                end
                if (!bwd_found_reg && bwd_gap_next >= len1 && rev_match1)
                begin
                    bwd_found_upd = 1'b1;
                end
            end
            else if (rev_match2)
            begin
                bwd_seen_next = 1'b1;
                bwd_gap_next  = '0;
            end
        end

        fwd_found_next = fwd_found_upd;
        bwd_found_next = bwd_found_upd;

        // The last byte of a text clears all search state.
        if (process && in_last_reg)
        begin
            window_next    = '0;
            fill_next      = '0;
            fwd_seen_next  = 1'b0;
            fwd_gap_next   = '0;
            fwd_found_next = 1'b0;
            bwd_seen_next  = 1'b0;
            bwd_gap_next   = '0;
            bwd_found_next = 1'b0;
        end
    end

    // Search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            fill_reg      <= '0;
            fwd_seen_reg  <= 1'b0;
            fwd_gap_reg   <= '0;
            fwd_found_reg <= 1'b0;
            bwd_seen_reg  <= 1'b0;
            bwd_gap_reg   <= '0;
            bwd_found_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            fwd_seen_reg  <= fwd_seen_next;
            fwd_gap_reg   <= fwd_gap_next;
            fwd_found_reg <= fwd_found_next;
            bwd_seen_reg  <= bwd_seen_next;
            bwd_gap_reg   <= bwd_gap_next;
            bwd_found_reg <= bwd_found_next;
        end
    end

    // Output register holds the verdict until its transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_valid_reg <= 1'b0;
        end
        else if (process && in_last_reg)
        begin
            verdict_valid_reg <= 1'b1;
        end
        else if (!verdict_stall)
        begin
            verdict_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && in_last_reg)
        begin
            verdict_reg[VERDICT_FWD_BIT] <= fwd_found_upd;
            verdict_reg[VERDICT_BWD_BIT] <= bwd_found_upd;
        end
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

`ifndef NO_ASSERTIONS
    // The input stalls only behind a waiting verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (verdict_valid_reg && verdict_stall && in_last_reg))
        else $error("input stalled without a blocked verdict");

    // Closing a text leaves the search state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_last_reg) |=> (fill_reg == '0 && !fwd_seen_reg && !bwd_seen_reg
                                      && !fwd_found_reg && !bwd_found_reg))
        else $error("search state not cleared after last byte");

    // A found flag needs its leading pattern to have been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_found_reg |-> fwd_seen_reg) and (bwd_found_reg |-> bwd_seen_reg))
        else $error("found flag set without leading pattern");

    // A gap only counts after the leading pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((fwd_gap_reg != '0) |-> fwd_seen_reg) and ((bwd_gap_reg != '0) |-> bwd_seen_reg))
        else $error("gap counting without leading pattern");
`endif

endmodule

`default_nettype wire
